// File: hdl/f2h_pkg.sv
`timescale 1ns / 1ps
package f2h_pkg;
	typedef enum logic {
		OP_S2H = 1'b0,
		OP_H2S = 1'b1
	} op_t;

	localparam logic [15:0] HALF_QNAN = 16'h7E00;
	localparam logic [15:0] HALF_INF  = 16'h7C00;
	localparam logic [12:0] HALF_TIE  = 13'h1000;
	localparam logic [7:0]  EXP_MAX   = 8'hFF;
	localparam logic [7:0]  EXP_OVF   = 8'd143;
	localparam logic [7:0]  EXP_NORM  = 8'd113;
	localparam logic [7:0]  EXP_TINY  = 8'd102;

	// class of a single-to-half request after stage one
	typedef enum logic [4:0] {
		CLS_NAN  = 5'b00001,
		CLS_INF  = 5'b00010,
		CLS_NORM = 5'b00100,
		CLS_SUB  = 5'b01000,
		CLS_ZERO = 5'b10000
	} cls_t;

	typedef struct packed {
		op_t        op;
		logic       sign;
		cls_t       cls;
		logic [7:0] exp;
		logic [22:0] man;
	} s1_t;
endpackage

// File: hdl/fp32_fp16_converter_core.sv
`timescale 1ns / 1ps
// Single/half precision bit pattern converter.
// Input channel: valid/ready with operation (0 = single to half,
// 1 = half to single) and operand_bits. Output channel: valid/ready
// with converted_bits; a half result sits in the low 16 bits, upper zero.
// Pipeline of three register stages: classify, shift/normalize, round and
// pack. After the accepting edge a request still passes the stage 2 and
// stage 3 registers before out_valid rises and the output handshake can come.
// Throughput is one request per cycle while out_ready stays high; each stage
// advances whenever the stage after it is empty or advancing, so a stall of
// the receiver backs up the stages one by one and then drops ready. Nothing
// is lost or repeated during a stall.
// Reset (arst_n low) clears all stage valid bits; no request is in flight
// afterwards and ready comes up at once.
// Rate: one request per cycle while out_ready stays high, set by the
// three-stage datapath with one barrel shift (single to half subnormal) and
// one leading-zero count (half to single subnormal), both in stage 2.
module fp32_fp16_converter_core
	import f2h_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic        operation,
	input  logic [31:0] operand_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] converted_bits
);
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;
	s1_t  d_s1;

	// stage 2 payload
	op_t         op_s2;
	logic        sign_s2;
	cls_t        cls_s2;
	logic [7:0]  exp_s2;
	logic [9:0]  kept_s2;
	logic        rbit_s2;
	logic        sticky_s2;
	logic [9:0]  hman_s2;
	logic [7:0]  hexp_s2;
	logic        hzero_s2;
	logic        hspec_s2;

	logic [31:0] res_s3;

	assign adv3  = v_s3 & out_ready;
	assign adv2  = !v_s3 || adv3;
	assign adv1  = !v_s2 || adv2;
	assign ready = !v_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready) v_s1 <= valid;
			if (adv1)  v_s2 <= v_s1;
			if (adv2)  v_s3 <= v_s2;
		end
	end

	// stage 1: classify
	s1_t d_in;
	always_comb begin
		d_in.op   = op_t'(operation);
		d_in.man  = operand_bits[22:0];
		if (operation == OP_H2S) begin
			d_in.sign = operand_bits[15];
			d_in.exp  = {3'b000, operand_bits[14:10]};
			d_in.man  = {operand_bits[9:0], 13'd0};
			d_in.cls  = CLS_NORM;
		end else begin
			d_in.sign = operand_bits[31];
			d_in.exp  = operand_bits[30:23];
			if (operand_bits[30:23] == EXP_MAX)
				d_in.cls = (operand_bits[22:0] != 23'd0) ? CLS_NAN : CLS_INF;
			else if (operand_bits[30:23] >= EXP_OVF)
				d_in.cls = CLS_INF;
			else if (operand_bits[30:23] >= EXP_NORM)
				d_in.cls = CLS_NORM;
			else if (operand_bits[30:23] < EXP_TINY)
				d_in.cls = CLS_ZERO;
			else
				d_in.cls = CLS_SUB;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid) d_s1 <= d_in;
	end

	// stage 2: subnormal shift for single to half, normalize for half to single
	logic [23:0] full;
	logic [4:0]  sh;
	logic [47:0] shifted;
	logic [3:0]  lz;
	logic [9:0]  hm;
	logic [9:0]  hm_norm;
	always_comb begin
		full    = {1'b1, d_s1.man};
		sh      = 5'(8'd126 - d_s1.exp);
		shifted = {full, 24'd0} >> sh;
		hm      = d_s1.man[22:13];
		lz      = 4'd10;
		for (int i = 0; i < 10; i++) begin
			if (hm[i]) lz = 4'(9 - i);
		end
		hm_norm = 10'(hm << (lz + 4'd1));
	end

	always_ff @(posedge clk) begin
		if (adv1 && v_s1) begin
			op_s2    <= d_s1.op;
			sign_s2  <= d_s1.sign;
			cls_s2   <= d_s1.cls;
			exp_s2   <= d_s1.exp;
			if (d_s1.cls == CLS_SUB) begin
				kept_s2   <= shifted[33:24];
				rbit_s2   <= shifted[23];
				sticky_s2 <= |shifted[22:0];
			end else begin
				kept_s2   <= d_s1.man[22:13];
				rbit_s2   <= d_s1.man[12];
				sticky_s2 <= |d_s1.man[11:0];
			end
			hzero_s2 <= (d_s1.exp[4:0] == 5'd0) && (hm == 10'd0);
			hspec_s2 <= (d_s1.exp[4:0] == 5'h1F);
			if (d_s1.exp[4:0] == 5'd0) begin
				hman_s2 <= hm_norm;
				hexp_s2 <= 8'(8'd113 - {4'd0, lz} - 8'd1);
			end else begin
				hman_s2 <= hm;
				hexp_s2 <= 8'({3'd0, d_s1.exp[4:0]} + 8'd112);
			end
		end
	end

	// stage 3: round and pack
	logic [15:0] base;
	logic        rup;
	logic [15:0] half;
	logic [31:0] single;
	always_comb begin
		rup = rbit_s2 && (sticky_s2 || kept_s2[0]);
		if (cls_s2 == CLS_SUB)
			base = {6'd0, kept_s2};
		else
			base = {1'b0, 5'(exp_s2 - 8'd112), kept_s2};
		base = base + {15'd0, rup};
		case (cls_s2)
			CLS_NAN:  half = {sign_s2, HALF_QNAN[14:0]};
			CLS_INF:  half = {sign_s2, HALF_INF[14:0]};
			CLS_ZERO: half = {sign_s2, 15'd0};
			default:  half = {sign_s2, base[14:0]};
		endcase
		if (hzero_s2)
			single = {sign_s2, 31'd0};
		else if (hspec_s2)
			single = {sign_s2, EXP_MAX, hman_s2, 13'd0};
		else
			single = {sign_s2, hexp_s2, hman_s2, 13'd0};
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s2)
			res_s3 <= (op_s2 == OP_H2S) ? single : {16'd0, half};
	end

	assign out_valid      = v_s3;
	assign converted_bits = res_s3;
endmodule

// File: bench/fp_conv_checker.sv
`timescale 1ns / 1ps
module fp_conv_checker
	import f2h_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	input  logic        ready,
	input  logic        operation,
	input  logic [31:0] operand_bits,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] converted_bits,
	output int          fail_count,
	output int          pending
);
	logic [31:0] expected_q[$];

	function automatic logic [15:0] to_half(logic [31:0] x);
		logic [15:0] sgn;
		logic [7:0] e;
		logic [22:0] m;
		logic [12:0] dropped;
		logic [15:0] base;
		logic [23:0] full, q, rem, halfway;
		int sh;
		sgn = {x[31], 15'd0};
		e = x[30:23];
		m = x[22:0];
		if (e == EXP_MAX)
			return sgn | (m != 0 ? HALF_QNAN : HALF_INF);
		if (e >= EXP_OVF)
			return sgn | HALF_INF;
		if (e >= EXP_NORM) begin
			dropped = m[12:0];
			base = {1'b0, e[4:0] - 5'd16, m[22:13]};
			base[14:10] = 5'(e - 8'd112);
			if (dropped > HALF_TIE || (dropped == HALF_TIE && m[13]))
				base = base + 16'd1;
			return sgn | base;
		end
		if (e < EXP_TINY)
			return sgn;
		full = {1'b1, m};
		sh = 126 - int'(e);
		q = full >> sh;
		rem = full & ((24'd1 << sh) - 24'd1);
		halfway = 24'd1 << (sh - 1);
		if (rem > halfway || (rem == halfway && q[0]))
			q = q + 24'd1;
		return sgn | q[15:0];
	endfunction

	function automatic logic [31:0] to_single(logic [15:0] h);
		logic [31:0] sgn;
		logic [4:0] ex;
		logic [10:0] mant;
		logic [7:0] fe;
		sgn = {h[15], 31'd0};
		ex = h[14:10];
		mant = {1'b0, h[9:0]};
		if (ex == 0) begin
			if (mant == 0)
				return sgn;
			fe = 8'd113;
			while (!mant[10]) begin
				mant = mant << 1;
				fe = fe - 8'd1;
			end
			return sgn | {1'b0, fe, mant[9:0], 13'd0};
		end
		if (ex == 5'h1F)
			return sgn | 32'h7F800000 | {9'd0, mant[9:0], 13'd0};
		return sgn | {1'b0, 8'(ex) + 8'd112, mant[9:0], 13'd0};
	endfunction

	assign pending = expected_q.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			if (valid && ready) begin
				if (op_t'(operation) == OP_S2H)
					expected_q.push_back({16'd0, to_half(operand_bits)});
				else
					expected_q.push_back(to_single(operand_bits[15:0]));
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result converted_bits=%h", converted_bits);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (converted_bits !== want) begin
						$error("converted_bits mismatch: expected %h actual %h",
							want, converted_bits);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// File: bench/tb_fp32_fp16_converter_core.sv
`timescale 1ns / 1ps
module tb_fp32_fp16_converter_core
	import f2h_pkg::*;
();
	localparam int STALL_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        valid = 1'b0;
	logic        ready;
	logic        operation = 1'b0;
	logic [31:0] operand_bits = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] converted_bits;
	int          fail_count;
	int          pending;
	bit          hold_sink = 1'b0;
	int          idle_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	fp32_fp16_converter_core dut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.operation(operation), .operand_bits(operand_bits),
		.out_valid(out_valid), .out_ready(out_ready),
		.converted_bits(converted_bits)
	);

	fp_conv_checker conv_check (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.operation(operation), .operand_bits(operand_bits),
		.out_valid(out_valid), .out_ready(out_ready),
		.converted_bits(converted_bits), .fail_count(fail_count),
		.pending(pending)
	);

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	// random single with bias toward exponents near the half range edges
	function automatic logic [31:0] rand_single();
		logic [31:0] v;
		v = $urandom();
		case ($urandom_range(0, 5))
			0: v[30:23] = 8'($urandom_range(100, 145));
			1: v[30:23] = 8'($urandom_range(110, 115));
			2: begin
				v[30:23] = 8'($urandom_range(113, 142));
				v[12:0] = 13'h1000;
			end
			3: v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: ;
		endcase
		return v;
	endfunction

	// valid stays high after acceptance unless a gap follows
	task automatic send(op_t op, logic [31:0] bits);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		valid <= 1'b1;
		operation <= op;
		operand_bits <= bits;
		@(posedge clk);
		while (!ready) @(posedge clk);
	endtask

	// receiver: random stalls, with a long hold when requested
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				out_ready <= 1'b0;
				repeat (60) @(posedge clk);
				hold_sink = 1'b0;
			end
			gap = gap_len();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else
				out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((valid && ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [31:0] corner[$];
		corner = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
			32'h7FC00001, 32'hFF800001, 32'h47800000, 32'h477FF000,
			32'h00000001, 32'h33000000, 32'h33000001, 32'h387FE000,
			32'h387FFFFF, 32'h3F801000, 32'h3F803000, 32'hFFFFFFFF};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (corner[i])
			send(OP_S2H, corner[i]);
		send(OP_H2S, 32'hFFFF0000);
		send(OP_H2S, 32'h00008001);
		send(OP_H2S, 32'h000003FF);
		send(OP_H2S, 32'h00007C00);
		send(OP_H2S, 32'h0000FE01);
		send(OP_H2S, 32'hA5A57BFF);
		send(OP_H2S, 32'h00000400);
		hold_sink = 1'b1;
		for (int i = 0; i < 20; i++) begin
			valid <= 1'b1;
			operation <= OP_S2H;
			operand_bits <= rand_single();
			@(posedge clk);
			while (!ready) @(posedge clk);
		end
		valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		for (int i = 0; i < 680; i++) begin
			if ($urandom_range(0, 1))
				send(OP_S2H, rand_single());
			else
				send(OP_H2S, $urandom());
			if (i == 300) begin
				valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end
		valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// File: files.f
hdl/f2h_pkg.sv
hdl/fp32_fp16_converter_core.sv
bench/fp_conv_checker.sv
bench/tb_fp32_fp16_converter_core.sv
